/* hdl/ssfp_pkg.sv */
// Shared types and constants for the seeded string fingerprint block.
`default_nettype none
package ssfp_pkg;

  localparam logic [31:0] GOLDEN_WORD   = 32'h9e37_79b9;
  localparam logic [31:0] SEED_LANE1    = 32'h0000_7a63;
  localparam logic [31:0] HASH_SEED_RST = 32'hfd12_deff;
  localparam logic        WIDE_MODE_RST = 1'b0;
  localparam logic [63:0] WIDE_FLIP     = 64'h130f_9bef_94a0_a928;

  localparam logic [3:0]  GROUP_LAST    = 4'd11;

  localparam int unsigned JOB_DEPTH     = 2;
  localparam int unsigned JOB_PTR_W     = 1;

  typedef enum logic [0:0] {
    CFG_HASH_SEED = 1'b0,
    CFG_WIDE_MODE = 1'b1
  } cfg_idx_e;

  // One mix request from the byte front end to the mixer.
  typedef struct packed {
    logic [31:0] ga;        // group sum for a
    logic [31:0] gb;        // group sum for b
    logic [31:0] gc;        // group sum for c
    logic [31:0] cnt;       // byte count so far
    logic        first;     // first job of a string: start from the seed values
    logic        two_pass;  // group mix, then final mix
    logic        is_final;  // string ends with this job
  } job_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lane_t;

endpackage
`default_nettype wire

/* hdl/ssfp_front.sv */
// Front end: takes bytes, builds 12-byte group sums and issues mix jobs.
`default_nettype none
module ssfp_front
  import ssfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       is_last_i,
  input  wire logic       is_empty_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output job_t            job_o
);

  logic [31:0] ga_q, gb_q, gc_q, cnt_q;
  logic [3:0]  pos_q;
  logic        first_q;

  logic        take, has_byte, grp_full;
  logic [31:0] ext, term;
  logic [31:0] ga_n, gb_n, gc_n, cnt_n;

  assign in_stall_o = q_full_i;

  always_comb begin
    ext = {{24{data_byte_i[7]}}, data_byte_i};
    case (pos_q[1:0])
      2'd0:    term = ext;
      2'd1:    term = {ext[23:0], 8'h00};
      2'd2:    term = {ext[15:0], 16'h0000};
      default: term = {ext[7:0], 24'h000000};
    endcase
    // an empty word that does not end the string is dropped
    take     = in_valid_i && !in_stall_o && !(is_empty_i && !is_last_i);
    has_byte = !is_empty_i;
    ga_n     = ga_q;
    gb_n     = gb_q;
    gc_n     = gc_q;
    if (has_byte) begin
      if (pos_q < 4'd4) begin
        ga_n = ga_q + term;
      end else if (pos_q < 4'd8) begin
        gb_n = gb_q + term;
      end else begin
        gc_n = gc_q + term;
      end
    end
    cnt_n    = cnt_q + {31'd0, has_byte};
    grp_full = has_byte && (pos_q == GROUP_LAST);
    push_o   = take && (grp_full || is_last_i);
    job_o    = '{ga: ga_n, gb: gb_n, gc: gc_n, cnt: cnt_n, first: first_q,
                 two_pass: grp_full && is_last_i, is_final: is_last_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ga_q    <= '0;
      gb_q    <= '0;
      gc_q    <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      first_q <= 1'b1;
    end else if (take) begin
      if (push_o) begin
        ga_q <= '0;
        gb_q <= '0;
        gc_q <= '0;
      end else begin
        ga_q <= ga_n;
        gb_q <= gb_n;
        gc_q <= gc_n;
      end
      if (is_last_i) begin
        cnt_q   <= '0;
        pos_q   <= '0;
        first_q <= 1'b1;
      end else begin
        cnt_q <= cnt_n;
        pos_q <= grp_full ? 4'd0 : pos_q + 4'd1;
        if (push_o) begin
          first_q <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/ssfp_job_fifo.sv */
// Short job queue between the byte front end and the mixer.
`default_nettype none
module ssfp_job_fifo
  import ssfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      job_o
);

  job_t                 mem_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [JOB_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (JOB_PTR_W+1)'(JOB_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/ssfp_mixer.sv */
// Back end: two hash lanes, one Mix row per cycle, and the result register.
`default_nettype none
module ssfp_mixer
  import ssfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] hash_seed_i,
  input  wire logic        wide_mode_i,
  input  wire logic        job_valid_i,
  input  wire job_t        job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      fingerprint_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_ROW,
    ST_FIN
  } state_e;

  localparam logic [3:0] ROW_LAST = 4'd8;

  state_e      state_q;
  job_t        job_q;
  lane_t       lane_q [2];
  logic [3:0]  row_q;
  logic        out_valid_q;
  logic [63:0] fp_q;

  logic [31:0] hi, lo;
  logic [63:0] result;
  logic        out_free;

  function automatic lane_t mix_row(lane_t l, logic [3:0] row);
    lane_t r;
    r = l;
    case (row)
      4'd0:    r.a = (l.a - l.b - l.c) ^ (l.c >> 13);
      4'd1:    r.b = (l.b - l.c - l.a) ^ (l.a << 8);
      4'd2:    r.c = (l.c - l.a - l.b) ^ (l.b >> 13);
      4'd3:    r.a = (l.a - l.b - l.c) ^ (l.c >> 12);
      4'd4:    r.b = (l.b - l.c - l.a) ^ (l.a << 16);
      4'd5:    r.c = (l.c - l.a - l.b) ^ (l.b >> 5);
      4'd6:    r.a = (l.a - l.b - l.c) ^ (l.c >> 3);
      4'd7:    r.b = (l.b - l.c - l.a) ^ (l.a << 10);
      4'd8:    r.c = (l.c - l.a - l.b) ^ (l.b >> 15);
      default: r = l;
    endcase
    return r;
  endfunction

  function automatic lane_t add_job(lane_t l, job_t j, logic [31:0] seed);
    lane_t       base, r;
    logic [31:0] cnt_term;
    base     = j.first ? lane_t'{a: GOLDEN_WORD, b: GOLDEN_WORD, c: seed} : l;
    cnt_term = (j.is_final && !j.two_pass) ? j.cnt : 32'd0;
    r.a      = base.a + j.ga;
    r.b      = base.b + j.gb;
    r.c      = base.c + j.gc + cnt_term;
    return r;
  endfunction

  assign pop_o         = (state_q == ST_IDLE) && job_valid_i;
  assign out_valid_o   = out_valid_q;
  assign fingerprint_o = fp_q;
  assign out_free      = !out_valid_q || !out_stall_i;

  always_comb begin
    hi = lane_q[0].c;
    lo = lane_q[1].c;
    if (wide_mode_i) begin
      result = {hi, lo};
      if ((hi == 32'd0) && (lo < 32'd2)) begin
        result = result ^ WIDE_FLIP;
      end
    end else begin
      result = {32'd0, hi};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= '0;
      lane_q[0]   <= '{a: GOLDEN_WORD, b: GOLDEN_WORD, c: HASH_SEED_RST};
      lane_q[1]   <= '{a: GOLDEN_WORD, b: GOLDEN_WORD, c: SEED_LANE1};
      row_q       <= '0;
      out_valid_q <= 1'b0;
      fp_q        <= '0;
    end else begin
      // drop the word once taken, unless a new one loads in the same cycle
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          lane_q[0] <= add_job(lane_q[0], job_q, hash_seed_i);
          lane_q[1] <= add_job(lane_q[1], job_q, SEED_LANE1);
          row_q     <= '0;
          state_q   <= ST_ROW;
        end
        ST_ROW: begin
          lane_q[0] <= mix_row(lane_q[0], row_q);
          lane_q[1] <= mix_row(lane_q[1], row_q);
          row_q     <= row_q + 4'd1;
          if (row_q == ROW_LAST) begin
            if (job_q.two_pass) begin
              // group mix done; next pass adds the length only
              job_q.ga       <= '0;
              job_q.gb       <= '0;
              job_q.gc       <= '0;
              job_q.first    <= 1'b0;
              job_q.two_pass <= 1'b0;
              state_q        <= ST_ADD;
            end else if (job_q.is_final) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_FIN: begin
          // hold until the result register frees up
          if (out_free) begin
            fp_q        <= result;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/seeded_string_fingerprint_core.sv */
// Top level of the seeded string fingerprint: config registers, front end, queue, mixer.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_stall_o data_byte_i, is_last_i, is_empty_i
//   out       output     out_valid_o / out_stall_i fingerprint_o
//   cfg       input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// Bytes are taken one per cycle while the queue has room. Group sums are built in the
// front end, so a group Mix (pop, one add step and nine Mix rows) overlaps the next 12
// bytes. A final job adds the result hand-off; when the last byte also closes a group,
// the job runs a second add and row pass for the length. For strings shorter than 12
// bytes the mixer sets the pace once the two-entry job queue is full. in_stall_o rises
// only when the queue is full. Reset clears control state at once.
`default_nettype none
module seeded_string_fingerprint_core
  import ssfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        is_last_i,
  input  wire logic        is_empty_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      fingerprint_o,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [31:0] hash_seed_q;
  logic        wide_mode_q;

  logic q_full, q_push, q_pop, q_valid;
  job_t front_job, head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_seed_q <= HASH_SEED_RST;
      wide_mode_q <= WIDE_MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HASH_SEED: hash_seed_q <= cfg_data_i;
        CFG_WIDE_MODE: wide_mode_q <= cfg_data_i[0];
        default:       hash_seed_q <= hash_seed_q;
      endcase
    end
  end

  ssfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .is_last_i   (is_last_i),
    .is_empty_i  (is_empty_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .job_o       (front_job)
  );

  ssfp_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  ssfp_mixer u_mixer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hash_seed_i   (hash_seed_q),
    .wide_mode_i   (wide_mode_q),
    .job_valid_i   (q_valid),
    .job_i         (head_job),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .fingerprint_o (fingerprint_o)
  );

endmodule
`default_nettype wire
